FILE: hdl/pfr_pkg.sv
// shared types, constants and coefficient table of the polyphase resampler
`default_nettype none
package pfr_pkg;

  localparam int TAPS        = 4;
  localparam int PHASES      = 64;
  localparam int MAX_RESULTS = 64;
  localparam int TAP_W       = $clog2(TAPS);
  localparam int PH_W        = $clog2(PHASES);
  localparam int RUN_W       = $clog2(MAX_RESULTS);
  localparam int COEF_IDX_W  = PH_W + TAP_W;
  // four floored s17 terms fit in 19 bits
  localparam int ACC_W       = 19;
  localparam int PROD_SHIFT  = 15;

  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 16;
  localparam int SKIP_W   = 8;
  localparam int PITCH_W  = 23;
  localparam int BUDGET_W = 16;
  localparam int SUM_W    = PHASE_W + SKIP_W;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam logic [PITCH_W-1:0]  PITCH_RESET  = 23'd65536;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'hffff;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 19'sd32767;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -19'sd32768;

  // register indexes
  localparam logic [1:0] REG_PITCH  = 2'd0;
  localparam logic [1:0] REG_HOLD   = 2'd1;
  localparam logic [1:0] REG_BUDGET = 2'd2;

  // command codes
  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_RESET   = 2'd1;
  localparam logic [1:0] CMD_RESTORE = 2'd2;
  localparam logic [1:0] CMD_SNAP    = 2'd3;

  localparam logic KIND_AUDIO = 1'b0;
  localparam logic KIND_SNAP  = 1'b1;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic signed [SAMPLE_W-1:0] restore_oldest;
    logic signed [SAMPLE_W-1:0] restore_second;
    logic signed [SAMPLE_W-1:0] restore_third;
    logic signed [SAMPLE_W-1:0] restore_newest;
    logic [PHASE_W-1:0]         restore_phase;
    logic [SKIP_W-1:0]          restore_skips;
  } in_t;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] out_value;
    logic                       run_last;
    logic                       budget_done;
    logic signed [SAMPLE_W-1:0] snap_oldest;
    logic signed [SAMPLE_W-1:0] snap_second;
    logic signed [SAMPLE_W-1:0] snap_third;
    logic signed [SAMPLE_W-1:0] snap_newest;
    logic [PHASE_W-1:0]         snap_phase;
    logic [SKIP_W-1:0]          snap_skips;
  } out_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
  } mac_ctl_t;

  localparam logic [15:0] COEF_TABLE [PHASES*TAPS] = '{
    16'h0c39, 16'h66ad, 16'h0d46, 16'hffdf, 16'h0b39, 16'h6696, 16'h0e5f, 16'hffd8,
    16'h0a44, 16'h6669, 16'h0f83, 16'hffd0, 16'h095a, 16'h6626, 16'h10b4, 16'hffc8,
    16'h087d, 16'h65cd, 16'h11f0, 16'hffbf, 16'h07ab, 16'h655e, 16'h1338, 16'hffb6,
    16'h06e4, 16'h64d9, 16'h148c, 16'hffac, 16'h0628, 16'h643f, 16'h15eb, 16'hffa1,
    16'h0577, 16'h638f, 16'h1756, 16'hff96, 16'h04d1, 16'h62cb, 16'h18cb, 16'hff8a,
    16'h0435, 16'h61f3, 16'h1a4c, 16'hff7e, 16'h03a4, 16'h6106, 16'h1bd7, 16'hff71,
    16'h031c, 16'h6007, 16'h1d6c, 16'hff64, 16'h029f, 16'h5ef5, 16'h1f0b, 16'hff56,
    16'h022a, 16'h5dd0, 16'h20b3, 16'hff48, 16'h01be, 16'h5c9a, 16'h2264, 16'hff3a,
    16'h015b, 16'h5b53, 16'h241e, 16'hff2c, 16'h0101, 16'h59fc, 16'h25e0, 16'hff1e,
    16'h00ae, 16'h5896, 16'h27a9, 16'hff10, 16'h0063, 16'h5720, 16'h297a, 16'hff02,
    16'h001f, 16'h559d, 16'h2b50, 16'hfef4, 16'hffe2, 16'h540d, 16'h2d2c, 16'hfee8,
    16'hffac, 16'h5270, 16'h2f0d, 16'hfedb, 16'hff7c, 16'h50c7, 16'h30f3, 16'hfed0,
    16'hff53, 16'h4f14, 16'h32dc, 16'hfec6, 16'hff2e, 16'h4d57, 16'h34c8, 16'hfebd,
    16'hff0f, 16'h4b91, 16'h36b6, 16'hfeb6, 16'hfef5, 16'h49c2, 16'h38a5, 16'hfeb0,
    16'hfedf, 16'h47ed, 16'h3a95, 16'hfeac, 16'hfece, 16'h4611, 16'h3c85, 16'hfeab,
    16'hfec0, 16'h4430, 16'h3e74, 16'hfeac, 16'hfeb6, 16'h424a, 16'h4060, 16'hfeaf,
    16'hfeaf, 16'h4060, 16'h424a, 16'hfeb6, 16'hfeac, 16'h3e74, 16'h4430, 16'hfec0,
    16'hfeab, 16'h3c85, 16'h4611, 16'hfece, 16'hfeac, 16'h3a95, 16'h47ed, 16'hfedf,
    16'hfeb0, 16'h38a5, 16'h49c2, 16'hfef5, 16'hfeb6, 16'h36b6, 16'h4b91, 16'hff0f,
    16'hfebd, 16'h34c8, 16'h4d57, 16'hff2e, 16'hfec6, 16'h32dc, 16'h4f14, 16'hff53,
    16'hfed0, 16'h30f3, 16'h50c7, 16'hff7c, 16'hfedb, 16'h2f0d, 16'h5270, 16'hffac,
    16'hfee8, 16'h2d2c, 16'h540d, 16'hffe2, 16'hfef4, 16'h2b50, 16'h559d, 16'h001f,
    16'hff02, 16'h297a, 16'h5720, 16'h0063, 16'hff10, 16'h27a9, 16'h5896, 16'h00ae,
    16'hff1e, 16'h25e0, 16'h59fc, 16'h0101, 16'hff2c, 16'h241e, 16'h5b53, 16'h015b,
    16'hff3a, 16'h2264, 16'h5c9a, 16'h01be, 16'hff48, 16'h20b3, 16'h5dd0, 16'h022a,
    16'hff56, 16'h1f0b, 16'h5ef5, 16'h029f, 16'hff64, 16'h1d6c, 16'h6007, 16'h031c,
    16'hff71, 16'h1bd7, 16'h6106, 16'h03a4, 16'hff7e, 16'h1a4c, 16'h61f3, 16'h0435,
    16'hff8a, 16'h18cb, 16'h62cb, 16'h04d1, 16'hff96, 16'h1756, 16'h638f, 16'h0577,
    16'hffa1, 16'h15eb, 16'h643f, 16'h0628, 16'hffac, 16'h148c, 16'h64d9, 16'h06e4,
    16'hffb6, 16'h1338, 16'h655e, 16'h07ab, 16'hffbf, 16'h11f0, 16'h65cd, 16'h087d,
    16'hffc8, 16'h10b4, 16'h6626, 16'h095a, 16'hffd0, 16'h0f83, 16'h6669, 16'h0a44,
    16'hffd8, 16'h0e5f, 16'h6696, 16'h0b39, 16'hffdf, 16'h0d46, 16'h66ad, 16'h0c39
  };

endpackage
`default_nettype wire

FILE: hdl/four_tap_polyphase_resampler.sv
// top level of the four-tap 64-phase polyphase resampler with sequencer and registers
//
// channel   direction  handshake               payload
// in_       request    in_valid / in_ready     pfr_pkg::in_t  in_data
// out_      result     out_valid / out_ready   pfr_pkg::out_t out_data
// config    apb write  psel penable pwrite     paddr[3:0], pwdata / prdata, pready tied high
//
// a request is taken while the sequencer is idle; a check step then decides whether to emit
// each interpolated output steps through decide, 4 taps through the one shared
// multiplier, accumulate drain and the write into the output register
// each hold-mode output goes through decide and write; a snapshot goes to its own write step
// in_ready is high only while the sequencer is idle; a full output register
// stalls the sequencer at its write step until out_ready takes the result
// synchronous active-low reset; state, registers and output valid go to reset values
`default_nettype none
module four_tap_polyphase_resampler (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // request channel
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire pfr_pkg::in_t                   in_data,
  // result channel
  output logic                                out_valid,
  input  wire                                 out_ready,
  output pfr_pkg::out_t                       out_data,
  // configuration port
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire logic [pfr_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [pfr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pfr_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import pfr_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_MAC   = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_SNAP  = 6'b100000
  } state_t;

  // configuration registers
  logic [PITCH_W-1:0]  pitch_r;
  logic                hold_r;
  logic [BUDGET_W-1:0] budget_r;

  // resampler state
  logic signed [SAMPLE_W-1:0] win_r [TAPS];
  logic signed [SAMPLE_W-1:0] win_nxt [TAPS];
  logic [PHASE_W-1:0]         phase_r, phase_nxt;
  logic [SKIP_W-1:0]          skips_r, skips_nxt;
  logic [BUDGET_W-1:0]        outs_left_r, outs_left_nxt;

  // sequencer
  state_t           state_r, state_nxt;
  logic [TAP_W-1:0] tap_r, tap_nxt;
  logic [RUN_W-1:0] run_cnt_r, run_cnt_nxt;

  // output register
  out_t out_r, out_nxt;
  logic out_vld_r, out_vld_nxt;
  logic slot_free;

  // shared multiply-accumulate
  mac_ctl_t                   mac_ctl;
  logic signed [SAMPLE_W-1:0] mac_sample;
  logic signed [SAMPLE_W-1:0] mac_coef;
  logic signed [ACC_W-1:0]    mac_acc;
  logic signed [SAMPLE_W-1:0] filt_val;
  logic signed [SAMPLE_W-1:0] emit_val;

  logic [SUM_W-1:0]    step_sum;
  logic [BUDGET_W-1:0] outs_dec;
  logic                emit_last;
  logic                cfg_wr;
  logic [1:0]          cfg_idx;

  // ---------------------------------------------------------------------------
  // configuration port: write in the access phase, pready always high
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r  <= PITCH_RESET;
      hold_r   <= 1'b0;
      budget_r <= BUDGET_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PITCH:  pitch_r  <= pwdata[PITCH_W-1:0];
        REG_HOLD:   hold_r   <= pwdata[0];
        REG_BUDGET: budget_r <= pwdata[BUDGET_W-1:0];
        default: ;  // no register at this address
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PITCH:  prdata = {{(CFG_DATA_W-PITCH_W){1'b0}}, pitch_r};
      REG_HOLD:   prdata = {{(CFG_DATA_W-1){1'b0}}, hold_r};
      REG_BUDGET: prdata = {{(CFG_DATA_W-BUDGET_W){1'b0}}, budget_r};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // tap operands: window sample and coefficient of the current phase set
  // ---------------------------------------------------------------------------
  assign mac_sample = win_r[tap_r];
  assign mac_coef   = COEF_TABLE[{phase_r[PHASE_W-1 -: PH_W], tap_r}];

  pfr_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .sample (mac_sample),
    .coef   (mac_coef),
    .acc    (mac_acc)
  );

  // clamp the accumulated sum to s16
  always_comb begin
    if (mac_acc > SAT_MAX) begin
      filt_val = SAT_MAX[SAMPLE_W-1:0];
    end else if (mac_acc < SAT_MIN) begin
      filt_val = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      filt_val = mac_acc[SAMPLE_W-1:0];
    end
  end

  // hold mode passes the oldest window sample
  assign emit_val = hold_r ? win_r[0] : filt_val;

  // phase advance: integer part becomes the skip count
  assign step_sum  = {{SKIP_W{1'b0}}, phase_r} + {{(SUM_W-PITCH_W){1'b0}}, pitch_r};
  assign outs_dec  = outs_left_r - 1'b1;
  // this output ends the run if the cap is reached, skips are pending or budget is gone
  assign emit_last = (run_cnt_r == RUN_W'(MAX_RESULTS - 1))
                     || (step_sum[SUM_W-1:PHASE_W] != '0)
                     || (outs_dec == '0);

  assign slot_free = !out_vld_r || out_ready;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    tap_nxt       = tap_r;
    run_cnt_nxt   = run_cnt_r;
    win_nxt       = win_r;
    phase_nxt     = phase_r;
    skips_nxt     = skips_r;
    outs_left_nxt = outs_left_r;
    out_nxt       = out_r;
    out_vld_nxt   = out_vld_r && !out_ready;
    mac_ctl       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          run_cnt_nxt = '0;
          state_nxt   = ST_CHECK;
          priority if (in_data.cmd == CMD_PUSH) begin
            for (int i = 0; i < TAPS - 1; i++) begin
              win_nxt[i] = win_r[i+1];
            end
            win_nxt[TAPS-1] = in_data.in_sample;
            if (skips_r != '0) begin
              skips_nxt = skips_r - 1'b1;
            end
          end else if (in_data.cmd == CMD_RESET) begin
            for (int i = 0; i < TAPS; i++) begin
              win_nxt[i] = '0;
            end
            phase_nxt     = '0;
            skips_nxt     = '0;
            outs_left_nxt = budget_r;
          end else if (in_data.cmd == CMD_RESTORE) begin
            win_nxt[0]    = in_data.restore_oldest;
            win_nxt[1]    = in_data.restore_second;
            win_nxt[2]    = in_data.restore_third;
            win_nxt[3]    = in_data.restore_newest;
            phase_nxt     = in_data.restore_phase;
            skips_nxt     = in_data.restore_skips;
            outs_left_nxt = budget_r;
          end else begin
            // snapshot reads the state as it stands
            state_nxt = ST_SNAP;
          end
        end
      end

      ST_CHECK: begin
        mac_ctl.clr = 1'b1;
        tap_nxt     = '0;
        if (skips_r == '0 && outs_left_r != '0) begin
          state_nxt = hold_r ? ST_EMIT : ST_MAC;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_MAC: begin
        mac_ctl.mul_en = 1'b1;
        tap_nxt        = tap_r + 1'b1;
        if (tap_r == TAP_W'(TAPS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        // last product lands in the accumulator
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_nxt             = '0;
          out_nxt.kind        = KIND_AUDIO;
          out_nxt.out_value   = emit_val;
          out_nxt.run_last    = emit_last;
          out_nxt.budget_done = (outs_dec == '0);
          out_vld_nxt         = 1'b1;
          outs_left_nxt       = outs_dec;
          skips_nxt           = step_sum[SUM_W-1:PHASE_W];
          phase_nxt           = step_sum[PHASE_W-1:0];
          run_cnt_nxt         = run_cnt_r + 1'b1;
          state_nxt           = emit_last ? ST_IDLE : ST_CHECK;
        end
      end

      ST_SNAP: begin
        if (slot_free) begin
          out_nxt             = '0;
          out_nxt.kind        = KIND_SNAP;
          out_nxt.run_last    = 1'b1;
          out_nxt.snap_oldest = win_r[0];
          out_nxt.snap_second = win_r[1];
          out_nxt.snap_third  = win_r[2];
          out_nxt.snap_newest = win_r[3];
          out_nxt.snap_phase  = phase_r;
          out_nxt.snap_skips  = skips_r;
          out_vld_nxt         = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    tap_r <= tap_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_cnt_r   <= '0;
      out_vld_r   <= 1'b0;
      phase_r     <= '0;
      skips_r     <= '0;
      outs_left_r <= BUDGET_RESET;
      for (int i = 0; i < TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      run_cnt_r   <= run_cnt_nxt;
      out_vld_r   <= out_vld_nxt;
      phase_r     <= phase_nxt;
      skips_r     <= skips_nxt;
      outs_left_r <= outs_left_nxt;
      win_r       <= win_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // no audio output is written once the budget is spent
  a_budget_guard: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (outs_left_r != '0))
    else $error("emit step entered with zero budget left");

  // the budget-ending output always closes its run
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.budget_done) |-> out_r.run_last)
    else $error("budget_done without run_last");

  // tap loop only leaves through the drain step
  a_mac_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |=> (state_r == ST_MAC || state_r == ST_DRAIN))
    else $error("tap loop left early");

  // every non-snapshot request goes to the emit decision next
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.cmd != CMD_SNAP) |=> (state_r == ST_CHECK))
    else $error("accepted request skipped the emit decision");

endmodule
`default_nettype wire

FILE: hdl/pfr_mac.sv
// shared multiply-accumulate unit: one tap product per cycle, floored and summed
`default_nettype none
module pfr_mac (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire pfr_pkg::mac_ctl_t                   ctl,
  input  wire logic signed [pfr_pkg::SAMPLE_W-1:0] sample,
  input  wire logic signed [pfr_pkg::SAMPLE_W-1:0] coef,
  output logic signed [pfr_pkg::ACC_W-1:0]         acc
);
  import pfr_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_W;

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     prod_vld_r, prod_vld_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod_shr;

  // arithmetic shift floors toward minus infinity
  assign prod_shr = prod_r >>> PROD_SHIFT;

  always_comb begin
    prod_nxt     = PROD_W'(sample) * PROD_W'(coef);
    prod_vld_nxt = ctl.mul_en;
    acc_nxt      = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + prod_shr[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      prod_vld_r <= prod_vld_nxt;
      acc_r      <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire
